// ----- rtl/wra_pkg.sv -----
// ----------------------------------------------------------------------------
// wra_pkg
// Shared types and constants for the whitening rotation block: field widths,
// command codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wra_pkg;

    // default vector dimension
    localparam int DIM_DEFAULT = 16;

    // largest index width over the supported dimension range (up to 64)
    localparam int IDX_MAX_W = 6;

    // payload widths
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int VAL_W      = 16;
    localparam int CENT_W     = 17;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_VAL_W  = 20;
    localparam int FRAC_SHIFT = 15;

    // configuration port
    localparam int                 DIM_CFG_W  = 5;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 5'd16;
    localparam int                 APB_DATA_W = 32;
    localparam int                 PADDR_W    = 3;
    localparam int                 REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_IN_USE = 1'b0;

    // input command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_MEAN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CENTER,
        ST_ISSUE,
        ST_WAIT
    } t_ctrl_state;

    // controller to datapath commands
    typedef struct packed {
        logic                 ld_mean;
        logic                 ld_coef;
        logic                 smp_latch;
        logic                 center_wr;
        logic [IDX_MAX_W-1:0] elem_idx;
        logic                 issue;
        logic                 first_col;
        logic                 last_col;
        logic [IDX_MAX_W-1:0] col;
        logic [IDX_MAX_W-1:0] row;
        logic                 last_row;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic row_done;
    } t_dp_status;

endpackage

// ----- rtl/wra_ctrl.sv -----
// ----------------------------------------------------------------------------
// wra_ctrl
// Controller: takes input transfers, counts vector elements and sequences
// the row by row multiply-accumulate passes of the datapath.
// ----------------------------------------------------------------------------
module wra_ctrl #(
    parameter int DIM = wra_pkg::DIM_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [wra_pkg::CMD_W-1:0]     i_cmd,
    input  logic [wra_pkg::DIM_CFG_W-1:0] i_dim_in_use,
    input  logic                          i_cfg_wr,
    input  wra_pkg::t_dp_status           i_status,
    output logic                          o_stall,
    output wra_pkg::t_dp_cmd              o_cmd
);
    import wra_pkg::*;

    localparam int IW = $clog2(DIM);
    localparam int CW = $clog2(DIM + 1);

    t_ctrl_state   r_state, n_state;
    logic [CW-1:0] r_elem, n_elem;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_col, n_col;

    logic [CW-1:0] eff_dim;
    logic [IW-1:0] elem_idx;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          last_elem;

    // effective vector length: zero acts as one, clamp at DIM
    always_comb begin
        if (i_dim_in_use == '0) begin
            eff_dim = CW'(1);
        end else if (32'(i_dim_in_use) > DIM) begin
            eff_dim = CW'(DIM);
        end else begin
            eff_dim = CW'(i_dim_in_use);
        end
    end

    assign elem_idx  = (r_elem >= eff_dim) ? '0 : r_elem[IW-1:0];
    assign last_elem = (CW'(elem_idx) + CW'(1)) == eff_dim;
    assign last_col  = (CW'(r_col) + CW'(1)) == eff_dim;
    assign last_row  = (CW'(r_row) + CW'(1)) == eff_dim;
    assign accept    = i_valid && (r_state == ST_IDLE);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_elem  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_elem  <= n_elem;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_elem  = r_elem;
        n_row   = r_row;
        n_col   = r_col;

        o_stall          = (r_state != ST_IDLE);
        o_cmd            = '0;
        o_cmd.elem_idx   = IDX_MAX_W'(elem_idx);
        o_cmd.col        = IDX_MAX_W'(r_col);
        o_cmd.row        = IDX_MAX_W'(r_row);
        o_cmd.first_col  = (r_col == '0);
        o_cmd.last_col   = last_col;
        o_cmd.last_row   = last_row;

        case (r_state)
            ST_IDLE: begin
                o_cmd.ld_mean   = accept && (i_cmd == CMD_LOAD_MEAN);
                o_cmd.ld_coef   = accept && (i_cmd == CMD_LOAD_COEF);
                o_cmd.smp_latch = accept && (i_cmd == CMD_SAMPLE);
                if (accept && (i_cmd == CMD_SAMPLE)) begin
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                o_cmd.center_wr = 1'b1;
                if (last_elem) begin
                    n_elem  = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = ST_ISSUE;
                end else begin
                    n_elem  = CW'(elem_idx) + CW'(1);
                    n_state = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (last_col) begin
                    n_col   = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_col = r_col + IW'(1);
                end
            end
            ST_WAIT: begin
                if (i_status.row_done) begin
                    if (last_row) begin
                        n_row   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_row   = r_row + IW'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new vector length drops a partly received vector
        if (i_cfg_wr) begin
            n_elem = '0;
        end
    end

endmodule

// ----- rtl/wra_datapath.sv -----
// ----------------------------------------------------------------------------
// wra_datapath
// Datapath: mean, coefficient and centered stores, the centering subtract,
// one pipelined multiply-accumulate unit, scaling with saturation and the
// output register.
// ----------------------------------------------------------------------------
module wra_datapath #(
    parameter int DIM = wra_pkg::DIM_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wra_pkg::t_dp_cmd                     i_cmd,
    input  logic        [wra_pkg::ROW_W-1:0]     i_row,
    input  logic        [wra_pkg::COL_W-1:0]     i_col,
    input  logic signed [wra_pkg::VAL_W-1:0]     i_value,
    input  logic                                 i_out_stall,
    output wra_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    output logic        [wra_pkg::OUT_IDX_W-1:0] o_out_index,
    output logic signed [wra_pkg::OUT_VAL_W-1:0] o_out_value,
    output logic                                 o_out_last
);
    import wra_pkg::*;

    localparam int IW      = $clog2(DIM);
    localparam int AW      = $clog2(DIM * DIM);
    localparam int PROD_W  = VAL_W + CENT_W;
    localparam int ACC_W   = PROD_W + $clog2(DIM) + 2;
    localparam int SAT_LSB = FRAC_SHIFT + OUT_VAL_W - 1;

    // stores
    logic signed [VAL_W-1:0]  mean_mem [DIM];
    logic signed [VAL_W-1:0]  coef_mem [DIM * DIM];
    logic signed [CENT_W-1:0] cent_mem [DIM];

    logic signed [VAL_W-1:0]  r_val;
    logic signed [VAL_W-1:0]  r_mean_q;
    logic signed [VAL_W-1:0]  r_coef_q;
    logic signed [CENT_W-1:0] r_cent_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1, r_v2, r_pend;
    logic                     r_first1, r_first2;
    logic                     r_last1, r_last2;

    logic                            r_out_valid;
    logic        [OUT_IDX_W-1:0]     r_out_index;
    logic signed [OUT_VAL_W-1:0]     r_out_value;
    logic                            r_out_last;

    logic                     ld_row_ok, ld_col_ok;
    logic [IW-1:0]            ld_row_idx, ld_col_idx;
    logic [AW-1:0]            ld_coef_addr;
    logic [AW-1:0]            mac_addr;
    logic [IW-1:0]            elem_idx, mac_col;
    logic signed [CENT_W-1:0] n_cent;
    logic                     sat_ok;
    logic signed [OUT_VAL_W-1:0] sat_val;
    logic                     out_take;
    logic                     out_load;

    // load addressing, out of range loads are dropped
    assign ld_row_ok    = 32'(i_row) < DIM;
    assign ld_col_ok    = 32'(i_col) < DIM;
    assign ld_row_idx   = IW'(i_row);
    assign ld_col_idx   = IW'(i_col);
    assign ld_coef_addr = AW'(ld_row_idx) * AW'(DIM) + AW'(ld_col_idx);

    assign elem_idx = i_cmd.elem_idx[IW-1:0];
    assign mac_col  = i_cmd.col[IW-1:0];
    assign mac_addr = AW'(i_cmd.row[IW-1:0]) * AW'(DIM) + AW'(mac_col);

    // centering subtract, always fits 17 bits
    assign n_cent = {r_val[VAL_W-1], r_val} - {r_mean_q[VAL_W-1], r_mean_q};

    // mean store and sample latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mean && ld_row_ok) begin
            mean_mem[ld_row_idx] <= i_value;
        end
        if (i_cmd.smp_latch) begin
            r_mean_q <= mean_mem[elem_idx];
            r_val    <= i_value;
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_coef && ld_row_ok && ld_col_ok) begin
            coef_mem[ld_coef_addr] <= i_value;
        end
        r_coef_q <= coef_mem[mac_addr];
    end

    // centered vector store
    always_ff @(posedge i_clk) begin
        if (i_cmd.center_wr) begin
            cent_mem[elem_idx] <= n_cent;
        end
        r_cent_q <= cent_mem[mac_col];
    end

    // multiply-accumulate pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (r_v2 && r_last2) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // multiply-accumulate pipeline data
    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first_col;
        r_last1  <= i_cmd.last_col;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_prod   <= r_coef_q * r_cent_q;
        if (r_v2) begin
            r_acc <= (r_first2 ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    // floor shift by 15 and saturate to 20 bits
    assign sat_ok = r_acc[ACC_W-1:SAT_LSB] == {(ACC_W - SAT_LSB){r_acc[ACC_W-1]}};
    always_comb begin
        if (sat_ok) begin
            sat_val = r_acc[SAT_LSB:FRAC_SHIFT];
        end else if (r_acc[ACC_W-1]) begin
            sat_val = {1'b1, {(OUT_VAL_W - 1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(OUT_VAL_W - 1){1'b1}}};
        end
    end

    // output register
    assign out_take = r_out_valid && !i_out_stall;
    assign out_load = r_pend && (!r_out_valid || out_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= OUT_IDX_W'(i_cmd.row[IW-1:0]);
            r_out_value <= sat_val;
            r_out_last  <= i_cmd.last_row;
        end
    end

    assign o_status.row_done = out_load;
    assign o_out_valid       = r_out_valid;
    assign o_out_index       = r_out_index;
    assign o_out_value       = r_out_value;
    assign o_out_last        = r_out_last;

endmodule

// ----- rtl/whitening_rotation_apply_top.sv -----
// A load item (mean element or matrix coefficient) leaves the input open. A sample
// element first reads the mean store as it is latched, then writes the
// centered value. The element that completes a vector of n elements starts
// the rotation, during which no input is taken: each of the n output rows
// runs through the single shared multiply-accumulate unit, its pipeline and
// the output register, and the rotation is held while the output side stalls.
// The last result of a vector waits in the output register while the next
// input transfers are already accepted. Stores have no reset; reading a mean
// or coefficient that was never loaded gives an undefined result.
// ----------------------------------------------------------------------------
// whitening_rotation_apply_top
// Applies y = W(x - mean) to one vector with a Q1.15 matrix, one output per
// row, scaled by 2^-15 and saturated to 20-bit signed.
// ----------------------------------------------------------------------------
module whitening_rotation_apply_top #(
    parameter int DIM = wra_pkg::DIM_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [wra_pkg::PADDR_W-1:0]    paddr,
    input  logic        [wra_pkg::APB_DATA_W-1:0] pwdata,
    output logic        [wra_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [wra_pkg::CMD_W-1:0]      i_cmd,
    input  logic        [wra_pkg::ROW_W-1:0]      i_row,
    input  logic        [wra_pkg::COL_W-1:0]      i_col,
    input  logic signed [wra_pkg::VAL_W-1:0]      i_value,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [wra_pkg::OUT_IDX_W-1:0]  o_out_index,
    output logic signed [wra_pkg::OUT_VAL_W-1:0]  o_out_value,
    output logic                                  o_last
);
    import wra_pkg::*;

    logic [DIM_CFG_W-1:0] r_dim_in_use;
    logic                 cfg_sel;
    logic                 cfg_wr;
    t_dp_cmd              dp_cmd;
    t_dp_status           dp_status;

    // register decode
    assign cfg_sel = paddr[PADDR_W-1:2] == REG_DIM_IN_USE;
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign pready  = 1'b1;

    // vector length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_in_use <= DIM_RESET;
        end else if (cfg_wr) begin
            r_dim_in_use <= pwdata[DIM_CFG_W-1:0];
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        if (cfg_sel) begin
            prdata = APB_DATA_W'(r_dim_in_use);
        end
    end

    wra_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_cmd        (i_cmd),
        .i_dim_in_use (r_dim_in_use),
        .i_cfg_wr     (cfg_wr),
        .i_status     (dp_status),
        .o_stall      (o_stall),
        .o_cmd        (dp_cmd)
    );

    wra_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_out_stall (i_stall),
        .o_status    (dp_status),
        .o_out_valid (o_valid),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_last)
    );

endmodule

// ----- rtl/wra_checker.sv -----
// ----------------------------------------------------------------------------
// wra_checker
// Port level checks for the whitening rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module wra_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic        [wra_pkg::CMD_W-1:0]     i_cmd,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic        [wra_pkg::OUT_IDX_W-1:0] o_out_index,
    input  logic signed [wra_pkg::OUT_VAL_W-1:0] o_out_value,
    input  logic                                 o_last
);
    import wra_pkg::*;

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value)
                               && $stable(o_out_index) && $stable(o_last))
        else $error("stalled result changed");

    // rows still to come keep the input side closed
    a_rows_block_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open while a vector is still being rotated");

    // loads never start a busy period
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == CMD_LOAD_MEAN || i_cmd == CMD_LOAD_COEF)
        |=> !o_stall)
        else $error("load transfer caused a stall");

endmodule

bind whitening_rotation_apply_top wra_checker u_wra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_index (o_out_index),
    .o_out_value (o_out_value),
    .o_last      (o_last)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for whitening_rotation_apply_top: loads mean and
// matrix stores, streams sample vectors at several vector lengths and checks
// every rotated element against a predicted y = W(x - mean) stream.
// ----------------------------------------------------------------------------
module testbench;
    import wra_pkg::*;

    localparam int                 DIM            = DIM_DEFAULT;
    localparam logic [CMD_W-1:0]   CMD_UNUSED     = 2'd3;
    localparam logic signed [15:0] VAL_MAX        = 16'sh7fff;
    localparam logic signed [15:0] VAL_MIN        = -16'sh8000;
    localparam int                 RAND_ITEMS     = 16;
    localparam int                 TAIL_ITEMS     = 8;
    localparam int                 SETTLE_CYCLES  = 10;
    localparam int                 WATCHDOG_LIMIT = 2000;

    // one rotated element as it leaves the block
    typedef struct packed {
        logic [OUT_IDX_W-1:0]        idx;
        logic signed [OUT_VAL_W-1:0] val;
        logic                        last;
    } t_rot_elem;

    // ------------------------------------------------------------------------
    // predictor: own copy of the stores, the vector length and element count
    // ------------------------------------------------------------------------
    class rotation_scoreboard;
        localparam int     N_MAX  = DIM_DEFAULT;
        localparam longint SAT_HI = (longint'(1) <<< (OUT_VAL_W - 1)) - 1;
        localparam longint SAT_LO = -(longint'(1) <<< (OUT_VAL_W - 1));

        logic [DIM_CFG_W-1:0]     length_reg = DIM_RESET;
        logic signed [VAL_W-1:0]  mean_mem[N_MAX];
        logic signed [VAL_W-1:0]  coef_mem[N_MAX][N_MAX];
        logic signed [CENT_W-1:0] centered_mem[N_MAX];
        int unsigned              elem_count = 0;
        t_rot_elem                expected_elems[$];

        // a new vector length drops any partly received vector
        function void set_length(logic [DIM_CFG_W-1:0] v);
            length_reg = v;
            elem_count = 0;
        endfunction

        // zero acts as one, anything above the store size as the store size
        function int unsigned active_dim();
            if (length_reg == 0) return 1;
            if (length_reg > N_MAX) return N_MAX;
            return length_reg;
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        // one output per row: dot product, floor shift, saturate
        function void rotate_vector(int unsigned n);
            longint    acc;
            longint    q;
            t_rot_elem e;
            for (int unsigned r = 0; r < n; r++) begin
                acc = 0;
                for (int unsigned c = 0; c < n; c++)
                    acc += longint'(coef_mem[r][c]) * longint'(centered_mem[c]);
                q = acc >>> FRAC_SHIFT;
                if (q > SAT_HI) q = SAT_HI;
                else if (q < SAT_LO) q = SAT_LO;
                e.idx  = OUT_IDX_W'(r);
                e.val  = OUT_VAL_W'(q);
                e.last = (r == n - 1);
                expected_elems.push_back(e);
            end
        endfunction

        // called once per accepted input transfer
        function void note_transfer(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                    logic [COL_W-1:0] col, logic signed [VAL_W-1:0] value);
            int unsigned n;
            case (cmd)
                CMD_LOAD_MEAN: begin
                    if (row < N_MAX) mean_mem[row] = value;
                end
                CMD_LOAD_COEF: begin
                    if (row < N_MAX && col < N_MAX) coef_mem[row][col] = value;
                end
                CMD_SAMPLE: begin
                    n = active_dim();
                    if (elem_count >= n) elem_count = 0;
                    centered_mem[elem_count] =
                        CENT_W'(int'(value) - int'(mean_mem[elem_count]));
                    elem_count++;
                    if (elem_count == n) begin
                        elem_count = 0;
                        rotate_vector(n);
                    end
                end
                default: ;
            endcase
        endfunction

        // returns an empty string when the element matches the oldest expectation
        function string check_transfer(logic [OUT_IDX_W-1:0] idx,
                                       logic signed [OUT_VAL_W-1:0] val, logic last);
            t_rot_elem want;
            string     msg;
            msg = "";
            if (expected_elems.size() == 0)
                return $sformatf("unexpected output index %0d value %0d last %0b",
                                 idx, val, last);
            want = expected_elems.pop_front();
            if (idx !== want.idx)
                msg = {msg, $sformatf(" index %0d/%0d", idx, want.idx)};
            if (val !== want.val)
                msg = {msg, $sformatf(" value %0d/%0d", val, want.val)};
            if (last !== want.last)
                msg = {msg, $sformatf(" last %0b/%0b", last, want.last)};
            if (msg != "") msg = {"output mismatch (got/want):", msg};
            return msg;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [PADDR_W-1:0]      paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [CMD_W-1:0]        i_cmd   = '0;
    logic [ROW_W-1:0]        i_row   = '0;
    logic [COL_W-1:0]        i_col   = '0;
    logic signed [VAL_W-1:0] i_value = '0;

    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [OUT_IDX_W-1:0]        o_out_index;
    logic signed [OUT_VAL_W-1:0] o_out_value;
    logic                        o_last;

    rotation_scoreboard sb;

    bit idle_enable = 1'b0;
    int mismatches  = 0;
    int n_loads     = 0;
    int n_samples   = 0;
    int n_ignored   = 0;
    int n_results   = 0;
    int n_lengths   = 0;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    whitening_rotation_apply_top #(
        .DIM(DIM)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // output side: check every transfer, random stall bursts
    // ------------------------------------------------------------------------
    int stall_run  = 0;
    bit stall_hold = 1'b0;

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            msg = sb.check_transfer(o_out_index, o_out_value, o_last);
            if (msg != "") report_mismatch(msg);
        end
        if (!idle_enable) begin
            stall_run = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_hold = ($urandom_range(0, 2) == 0);
                stall_run  = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
            end
            stall_run--;
            i_stall <= stall_hold;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // input side drivers
    // ------------------------------------------------------------------------
    // biased toward the extremes so saturation shows up often
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col,
                             input logic signed [VAL_W-1:0] value);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_row   <= row;
        i_col   <= col;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        sb.note_transfer(cmd, row, col, value);
        case (cmd)
            CMD_LOAD_MEAN, CMD_LOAD_COEF: n_loads++;
            CMD_SAMPLE:                   n_samples++;
            default:                      n_ignored++;
        endcase
    endtask

    task automatic send_samples(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 11) == 0)
                push_item(CMD_UNUSED, ROW_W'($urandom), COL_W'($urandom), pick_value());
            push_item(CMD_SAMPLE, ROW_W'($urandom), COL_W'($urandom), pick_value());
        end
    endtask

    task automatic load_random();
        if ($urandom_range(0, 3) == 0)
            push_item(CMD_LOAD_MEAN, ROW_W'($urandom), COL_W'($urandom), pick_value());
        else
            push_item(CMD_LOAD_COEF, ROW_W'($urandom), COL_W'($urandom), pick_value());
    endtask

    // idle the input, let every result drain, then allow the block to finish
    task automatic settle_block();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_length(input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DIM_IN_USE, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_length(data[DIM_CFG_W-1:0]);
        n_lengths++;
    endtask

    // mostly short vectors, with the clamped codes and the largest size mixed in
    function automatic logic [APB_DATA_W-1:0] pick_length_word();
        logic [APB_DATA_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(1, 4));
            6, 7:             w[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(5, 16));
            8:                w[DIM_CFG_W-1:0] = '0;
            default:          w[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(17, 31));
        endcase
        if ($urandom_range(0, 3) != 0) w[APB_DATA_W-1:DIM_CFG_W] = '0;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        int          base_items;
        int          rand_items;
        bit          tail;

        sb = new;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_enable = 1'b1;

        // fill both stores so no entry is ever read before it is written
        for (int k = 0; k < DIM; k++)
            push_item(CMD_LOAD_MEAN, ROW_W'(k), COL_W'($urandom), VAL_MIN);
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                push_item(CMD_LOAD_COEF, ROW_W'(r), COL_W'(c),
                          (r == 0) ? VAL_MAX : (r == 1) ? VAL_MIN : pick_value());
            end
        end

        // reset length, widest centered values: row 0 and row 1 saturate both ways
        repeat (DIM) push_item(CMD_SAMPLE, ROW_W'($urandom), COL_W'($urandom), VAL_MAX);

        // unused command code is dropped
        push_item(CMD_UNUSED, '1, '1, VAL_MAX);
        push_item(CMD_UNUSED, '0, '0, VAL_MIN);

        // single element vectors, zero length acts as one
        settle_block();
        write_length(32'd1);
        send_samples(1);
        settle_block();
        write_length(32'd0);
        send_samples(1);

        // oversized lengths clamp; a new length drops the partial vector
        settle_block();
        write_length(32'd31);
        send_samples(2);
        settle_block();
        write_length(32'd17);
        send_samples(2);
        settle_block();
        write_length(32'd2);
        send_samples(2);

        // short random phase: mostly complete vectors with loads mixed in
        base_items = n_loads + n_samples;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            tail        = (rand_items + TAIL_ITEMS >= RAND_ITEMS);
            idle_enable = tail ? 1'b0 : ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                settle_block();
                write_length(pick_length_word());
            end
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 3)) load_random();
                n = sb.active_dim();
                if (!tail && $urandom_range(0, 7) == 0)
                    send_samples($urandom_range(0, n - 1));
                else
                    send_samples(n);
            end
            rand_items = n_loads + n_samples - base_items;
        end

        // drain and close
        idle_enable = 1'b0;
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers: %0d loads, %0d samples, %0d dropped commands",
                 n_loads + n_samples + n_ignored, n_loads, n_samples, n_ignored);
        $display("checked %0d rotated elements across %0d length writes, %0d mismatches",
                 n_results, n_lengths, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
